>>> rtl/core/pidc_pkg.sv
package pidc_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int GAIN_W     = 32;
	localparam int ERR_W      = SAMPLE_W + 1;
	localparam int DERR_W     = ERR_W + 1;
	localparam int PROD_E_W   = GAIN_W + ERR_W;
	localparam int PROD_D_W   = GAIN_W + DERR_W;
	localparam int INTEG_W    = 48;
	localparam int RAW_W      = 53;
	localparam int FRAC_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROP_GAIN       = 3'd0,
		REG_INTEGRAL_GAIN   = 3'd1,
		REG_DERIVATIVE_GAIN = 3'd2,
		REG_OUT_UPPER       = 3'd3,
		REG_OUT_LOWER       = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		CLAMP_NONE  = 2'd0,
		CLAMP_UPPER = 2'd1,
		CLAMP_LOWER = 2'd2
	} clamp_t;

	localparam logic CMD_UPDATE = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	typedef struct packed {
		logic signed [GAIN_W-1:0]   prop_gain;
		logic signed [GAIN_W-1:0]   integral_gain;
		logic signed [GAIN_W-1:0]   derivative_gain;
		logic signed [SAMPLE_W-1:0] out_upper;
		logic signed [SAMPLE_W-1:0] out_lower;
	} cfg_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] drive;
		clamp_t                     clamp;
		logic signed [INTEG_W-1:0]  integ_next;
		logic signed [ERR_W-1:0]    err_next;
	} core_res_t;

endpackage

>>> rtl/core/pidc_in_if.sv
interface pidc_in_if;
	logic               valid;
	logic               ready;
	logic               cmd;
	logic signed [15:0] target;
	logic signed [15:0] measured;

	modport source (output valid, output cmd, output target, output measured, input ready);
	modport sink (input valid, input cmd, input target, input measured, output ready);
endinterface

>>> rtl/core/pidc_out_if.sv
interface pidc_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] drive;
	logic [1:0]         clamp_state;

	modport source (output valid, output drive, output clamp_state, input ready);
	modport sink (input valid, input drive, input clamp_state, output ready);
endinterface

>>> rtl/core/pidc_cfg.sv
module pidc_cfg import pidc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wen,
	input  logic [CFG_IDX_W-1:0]  index,
	input  logic [CFG_DATA_W-1:0] data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain       <= '0;
			cfg_q.integral_gain   <= '0;
			cfg_q.derivative_gain <= '0;
			cfg_q.out_upper       <= 16'sh7FFF;
			cfg_q.out_lower       <= 16'sh8000;
		end else if (wen) begin
			case (index)
				REG_PROP_GAIN:       cfg_q.prop_gain       <= data;
				REG_INTEGRAL_GAIN:   cfg_q.integral_gain   <= data;
				REG_DERIVATIVE_GAIN: cfg_q.derivative_gain <= data;
				REG_OUT_UPPER:       cfg_q.out_upper       <= data[SAMPLE_W-1:0];
				REG_OUT_LOWER:       cfg_q.out_lower       <= data[SAMPLE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/core/pidc_core.sv
module pidc_core import pidc_pkg::*; (
	input  cfg_t                       cfg,
	input  logic                       cmd,
	input  logic signed [SAMPLE_W-1:0] target,
	input  logic signed [SAMPLE_W-1:0] measured,
	input  logic signed [INTEG_W-1:0]  integ,
	input  logic signed [ERR_W-1:0]    last_err,
	output core_res_t                  res
);

	logic signed [ERR_W-1:0]    err;
	logic signed [DERR_W-1:0]   derr;
	logic signed [PROD_E_W-1:0] p_term;
	logic signed [PROD_E_W-1:0] i_term;
	logic signed [PROD_D_W-1:0] d_term;
	logic signed [RAW_W-1:0]    cand;
	logic signed [RAW_W-1:0]    raw;
	logic signed [RAW_W-1:0]    hi;
	logic signed [RAW_W-1:0]    lo;
	logic signed [RAW_W-1:0]    cand_adj;
	logic signed [INTEG_W-1:0]  integ_sat;
	logic signed [SAMPLE_W-1:0] drive;
	clamp_t                     clamp;

	assign err  = ERR_W'(target) - ERR_W'(measured);
	assign derr = DERR_W'(err) - DERR_W'(last_err);

	assign p_term = PROD_E_W'(cfg.prop_gain) * PROD_E_W'(err);
	assign i_term = PROD_E_W'(cfg.integral_gain) * PROD_E_W'(err);
	assign d_term = PROD_D_W'(cfg.derivative_gain) * PROD_D_W'(derr);

	assign cand = RAW_W'(integ) + RAW_W'(i_term);
	assign raw  = RAW_W'(p_term) + cand + RAW_W'(d_term);

	assign hi = {{(RAW_W-SAMPLE_W-FRAC_W){cfg.out_upper[SAMPLE_W-1]}}, cfg.out_upper,
		{FRAC_W{1'b0}}};
	assign lo = {{(RAW_W-SAMPLE_W-FRAC_W){cfg.out_lower[SAMPLE_W-1]}}, cfg.out_lower,
		{FRAC_W{1'b0}}};

	// The upper limit is tested first, so a value beyond both crossed limits resolves to the upper one.
	always_comb begin
		if (raw > hi) begin
			drive    = cfg.out_upper;
			clamp    = CLAMP_UPPER;
			cand_adj = cand - (raw - hi);
		end else if (raw < lo) begin
			drive    = cfg.out_lower;
			clamp    = CLAMP_LOWER;
			cand_adj = cand - (raw - lo);
		end else begin
			drive    = raw[FRAC_W+SAMPLE_W-1:FRAC_W];
			clamp    = CLAMP_NONE;
			cand_adj = cand;
		end
	end

	// The integrator saturates when the bits above its sign bit disagree with it.
	always_comb begin
		if (cand_adj[RAW_W-1:INTEG_W-1] == {(RAW_W-INTEG_W+1){cand_adj[RAW_W-1]}}) begin
			integ_sat = cand_adj[INTEG_W-1:0];
		end else if (cand_adj[RAW_W-1]) begin
			integ_sat = {1'b1, {(INTEG_W-1){1'b0}}};
		end else begin
			integ_sat = {1'b0, {(INTEG_W-1){1'b1}}};
		end
	end

	always_comb begin
		if (cmd == CMD_CLEAR) begin
			res.drive      = '0;
			res.clamp      = CLAMP_NONE;
			res.integ_next = '0;
			res.err_next   = '0;
		end else begin
			res.drive      = drive;
			res.clamp      = clamp;
			res.integ_next = integ_sat;
			res.err_next   = err;
		end
	end

endmodule

>>> rtl/core/pid_controller_antiwindup.sv
// Fixed-point PID controller with back-calculation anti-windup. Each transfer on
// the update channel carries a setpoint and a measurement (or a clear command) and
// produces exactly one transfer on the result channel: the clamped drive value and
// a code telling whether it sits within limits or at the upper or lower limit.
// The block sustains one item per clock cycle while results are taken. An accepted
// item is held in an input register while the three gain multiplies, the sum, the
// clamp and the integrator update run; the result is then registered in the result
// register and offered on the result channel. The rate of one item per cycle is set
// by the integrator and previous-error feedback, which is closed combinationally
// between registers through the integral multiply, the wide sum and the limit
// compare. Gains and limits are written through the plain write port and should
// only change while no item is in flight.
module pid_controller_antiwindup import pidc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	pidc_in_if.sink               update,
	pidc_out_if.source            result,
	input  logic                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t      cfg;
	core_res_t res;

	// Input register stage.
	logic                       valid_s1;
	logic                       cmd_s1;
	logic signed [SAMPLE_W-1:0] target_s1;
	logic signed [SAMPLE_W-1:0] measured_s1;

	// Controller state, updated when an item moves into the result register.
	logic signed [INTEG_W-1:0] integ_q;
	logic signed [ERR_W-1:0]   last_err_q;

	// Result register.
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] drive_q;
	clamp_t                     clamp_q;

	logic out_free;
	logic move_s1;
	logic take_in;

	pidc_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wen    (cfg_wen),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	pidc_core u_core (
		.cfg      (cfg),
		.cmd      (cmd_s1),
		.target   (target_s1),
		.measured (measured_s1),
		.integ    (integ_q),
		.last_err (last_err_q),
		.res      (res)
	);

	// The result register frees up when it is empty or its transfer completes, so
	// a new item can enter every cycle as long as each result on offer is taken.
	assign out_free = !out_valid_q || result.ready;
	assign move_s1  = valid_s1 && out_free;
	assign take_in  = update.valid && update.ready;

	assign update.ready = !valid_s1 || move_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take_in || (valid_s1 && !move_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			cmd_s1      <= update.cmd;
			target_s1   <= update.target;
			measured_s1 <= update.measured;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q    <= '0;
			last_err_q <= '0;
		end else if (move_s1) begin
			integ_q    <= res.integ_next;
			last_err_q <= res.err_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= move_s1 || (out_valid_q && !result.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			drive_q <= res.drive;
			clamp_q <= res.clamp;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.drive       = drive_q;
	assign result.clamp_state = clamp_q;

`ifndef SYNTHESIS
	// Controller state only changes when an item leaves the input register.
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!move_s1 |=> ($stable(integ_q) && $stable(last_err_q)))
		else $error("controller state changed without an item being processed");

	// A clear command leaves zero state and a zero result behind.
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(move_s1 && cmd_s1 == CMD_CLEAR) |=>
		(integ_q == '0 && last_err_q == '0 && out_valid_q && drive_q == '0 &&
		clamp_q == CLAMP_NONE))
		else $error("clear command did not zero state and result");

	// An empty input register always takes a new item.
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> update.ready)
		else $error("update channel stalled with an empty input register");

	// An item in the input register moves on whenever the result side can take it.
	a_no_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && result.ready) |=> out_valid_q)
		else $error("processed item did not reach the result register");
`endif

endmodule
